>>> src/tpa_pkg.sv
package tpa_pkg;

   // width of the vertex index that is kept; it spans the whole input word
   localparam int INDEX_BITS = 32;

   localparam int WORD_BITS   = 32;
   localparam int STATUS_BITS = 3;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [INDEX_BITS-1:0] index_type;

   typedef enum logic [1:0] {
      TOPO_LIST   = 2'd0,
      TOPO_STRIP  = 2'd1,
      TOPO_FAN    = 2'd2,
      TOPO_POINTS = 2'd3
   } topology_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_TRIANGLE    = 3'd0,
      STATUS_NONE_YET    = 3'd1,
      STATUS_OUT_OF_RANGE = 3'd2,
      STATUS_LIST_SHORT  = 3'd3,
      STATUS_UNSUPPORTED = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TOPOLOGY     = 2'd0,
      CSR_MIRROR       = 2'd1,
      CSR_VERTEX_COUNT = 2'd2,
      CSR_BASE_VERTEX  = 2'd3
   } csr_index_type;

   // one assembled result as it leaves the block
   typedef struct packed {
      logic [WORD_BITS-1:0] corner_c;
      logic [WORD_BITS-1:0] corner_b;
      logic [WORD_BITS-1:0] corner_a;
      status_type           status;
      logic                 end_of_primitive;
   } result_type;

endpackage

>>> src/triangle_primitive_assembler.sv
// Triangle primitive assembler.
// req channel: one vertex index per transfer in req_tdata, req_tlast on the
// final index of a primitive. rsp channel: exactly one result per accepted
// index; rsp_tdata carries three corners (index plus base vertex), rsp_tuser
// the status (0 triangle, 1 none yet, 2 index out of range, 3 list not a
// multiple of three, 4 unsupported topology), rsp_tlast echoes req_tlast.
// Corners read zero when status is not 0. After an error the primitive
// reports "none yet" until its last index.
// csr port: write-only registers topology, mirror_winding, vertex_count and
// base_vertex, written only while the block is idle; the user is bound to
// this, and the block itself does not enforce it. A req transfer is held in
// the output register, or in the skid register while the receiver stalls,
// before rsp_tvalid shows it; one index is taken every cycle while the skid
// register is empty. A stalled receiver holds the output register, and one
// more index is taken into a skid register; req_tready drops only while the
// skid register is full. Synchronous reset clears configuration, primitive state and valids.
module triangle_primitive_assembler
   import tpa_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [WORD_BITS-1:0]      req_tdata,  // vertex_index
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [3*WORD_BITS-1:0]    rsp_tdata,  // corner_a, corner_b, corner_c
   output logic [STATUS_BITS-1:0]    rsp_tuser,  // status
   output logic                      rsp_tlast,  // end_of_primitive
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [WORD_BITS-1:0]      csr_wdata
);

   // configuration registers
   topology_type         topology_ff;
   logic                 mirror_ff;
   logic [WORD_BITS-1:0] vertex_count_ff;
   logic [WORD_BITS-1:0] base_vertex_ff;

   // primitive state
   index_type  first_index_ff, first_index_in;
   index_type  older_index_ff, older_index_in;
   index_type  newer_index_ff, newer_index_in;
   logic [1:0] seen_count_ff, seen_count_in;
   logic       strip_parity_ff, strip_parity_in;
   logic [1:0] list_phase_ff, list_phase_in;
   logic       failed_ff, failed_in;

   // output and skid stages
   result_type out_ff, out_in;
   logic       out_valid_ff, out_valid_in;
   result_type skid_ff, skid_in;
   logic       skid_valid_ff, skid_valid_in;

   logic       req_xfer;
   logic       out_load;
   index_type  idx;
   logic       in_range;
   logic       emit;
   index_type  raw_a, raw_b, raw_c;
   index_type  fin_b, fin_c;
   status_type status;
   result_type result;

   assign req_tready = !skid_valid_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign out_load   = !out_valid_ff || rsp_tready;

   assign idx      = req_tdata[INDEX_BITS-1:0];
   assign in_range = WORD_BITS'(idx) < vertex_count_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         topology_ff     <= TOPO_LIST;
         mirror_ff       <= 1'b0;
         vertex_count_ff <= '0;
         base_vertex_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_TOPOLOGY:     topology_ff     <= topology_type'(csr_wdata[1:0]);
            CSR_MIRROR:       mirror_ff       <= csr_wdata[0];
            CSR_VERTEX_COUNT: vertex_count_ff <= csr_wdata;
            CSR_BASE_VERTEX:  base_vertex_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // assembly of one index against the primitive state
   always_comb begin
      first_index_in  = first_index_ff;
      older_index_in  = older_index_ff;
      newer_index_in  = newer_index_ff;
      seen_count_in   = seen_count_ff;
      strip_parity_in = strip_parity_ff;
      list_phase_in   = list_phase_ff;
      failed_in       = failed_ff;
      emit            = 1'b0;
      raw_a           = older_index_ff;
      raw_b           = newer_index_ff;
      raw_c           = idx;
      status          = STATUS_NONE_YET;

      if (failed_ff) begin
         // silent until the end of the primitive
      end else if (topology_ff == TOPO_POINTS) begin
         status    = STATUS_UNSUPPORTED;
         failed_in = 1'b1;
      end else if (!in_range) begin
         status    = STATUS_OUT_OF_RANGE;
         failed_in = 1'b1;
      end else begin
         unique case (topology_ff)
            TOPO_LIST: begin
               if (list_phase_ff == 2'd0) begin
                  older_index_in = idx;
                  list_phase_in  = 2'd1;
               end else if (list_phase_ff == 2'd1) begin
                  newer_index_in = idx;
                  list_phase_in  = 2'd2;
               end else begin
                  emit          = 1'b1;
                  list_phase_in = 2'd0;
               end
               if (req_tlast && list_phase_in != 2'd0) begin
                  status = STATUS_LIST_SHORT;
               end
            end
            TOPO_STRIP: begin
               if (seen_count_ff == 2'd2) begin
                  emit = 1'b1;
                  // odd triangles flip winding
                  if (strip_parity_ff) begin
                     raw_b = idx;
                     raw_c = newer_index_ff;
                  end
                  strip_parity_in = !strip_parity_ff;
               end else begin
                  seen_count_in = seen_count_ff + 2'd1;
               end
               older_index_in = newer_index_ff;
               newer_index_in = idx;
            end
            default: begin
               // fan pivots on the first index
               if (seen_count_ff == 2'd0) begin
                  first_index_in = idx;
                  seen_count_in  = 2'd1;
               end else if (seen_count_ff == 2'd1) begin
                  newer_index_in = idx;
                  seen_count_in  = 2'd2;
               end else begin
                  emit           = 1'b1;
                  raw_a          = newer_index_ff;
                  raw_b          = idx;
                  raw_c          = first_index_ff;
                  newer_index_in = idx;
               end
            end
         endcase
         if (emit) begin
            status = STATUS_TRIANGLE;
         end
      end

      // end of primitive clears everything
      if (req_tlast) begin
         first_index_in  = '0;
         older_index_in  = '0;
         newer_index_in  = '0;
         seen_count_in   = '0;
         strip_parity_in = 1'b0;
         list_phase_in   = '0;
         failed_in       = 1'b0;
      end
   end

   // mirror swap and base offset
   always_comb begin
      fin_b = mirror_ff ? raw_c : raw_b;
      fin_c = mirror_ff ? raw_b : raw_c;
      result.status           = status;
      result.end_of_primitive = req_tlast;
      if (emit) begin
         result.corner_a = WORD_BITS'(raw_a) + base_vertex_ff;
         result.corner_b = WORD_BITS'(fin_b) + base_vertex_ff;
         result.corner_c = WORD_BITS'(fin_c) + base_vertex_ff;
      end else begin
         result.corner_a = '0;
         result.corner_b = '0;
         result.corner_c = '0;
      end
   end

   // state update on each accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         first_index_ff  <= '0;
         older_index_ff  <= '0;
         newer_index_ff  <= '0;
         seen_count_ff   <= '0;
         strip_parity_ff <= 1'b0;
         list_phase_ff   <= '0;
         failed_ff       <= 1'b0;
      end else if (req_xfer) begin
         first_index_ff  <= first_index_in;
         older_index_ff  <= older_index_in;
         newer_index_ff  <= newer_index_in;
         seen_count_ff   <= seen_count_in;
         strip_parity_ff <= strip_parity_in;
         list_phase_ff   <= list_phase_in;
         failed_ff       <= failed_in;
      end
   end

   // output register with one skid entry
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_load) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = req_xfer;
         end
      end else if (req_xfer) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.corner_c, out_ff.corner_b, out_ff.corner_a};
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.end_of_primitive;

`ifndef SYNTHESIS
   // skid entry is only used behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid without output valid");

   // corners are zero unless a triangle is reported
   a_corners_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.status != STATUS_TRIANGLE) |-> (rsp_tdata == '0))
      else $error("nonzero corners on a non-triangle result");

   // a last index leaves the primitive state cleared
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_tlast) |=>
         (seen_count_ff == 2'd0 && list_phase_ff == 2'd0 && !failed_ff
          && !strip_parity_ff))
      else $error("primitive state not cleared after last index");

   // seen count saturates at two
   a_seen_saturates: assert property (@(posedge clock) disable iff (reset)
      seen_count_ff != 2'd3)
      else $error("seen count beyond two");
`endif

endmodule
